// ===== rtl/core/fesg_pkg.sv =====
// Shared types and widths for the filled ellipse span generator.
// Used by the controller, the datapath and the top level; depends on nothing.
package fesg_pkg;

    localparam int CX_W    = 7;
    localparam int CY_W    = 6;
    localparam int RX_W    = 6;
    localparam int RY_W    = 5;
    localparam int ROW_W   = 6;   // signed row offset, -31 .. +31
    localparam int RX2_W   = 12;  // radius_x squared
    localparam int RY2_W   = 10;  // radius_y squared, also row offset squared
    localparam int PROD_W  = 22;  // rx^2 * ry^2 and y^2 * rx^2
    localparam int STEP_W  = 17;  // (2w - 1) * ry^2
    localparam int SPAN_W  = 8;
    localparam int IN_DATA_W  = 32;
    localparam int OUT_DATA_W = 32;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;       // latch a new draw command
        logic square;     // square both radii
        logic limit;      // form the bound and the first width step
        logic row_square; // square the row offset
        logic row_init;   // start the width search of a row
        logic step;       // narrow the half width by one pixel
        logic row_next;   // advance to the next row
    } ctrl_cmd_t;

    // Status from the datapath back to the controller.
    typedef struct packed {
        logic search_done; // current half width fits inside the ellipse
        logic last_row;    // current row is the bottom row
    } dp_status_t;

endpackage

// ===== rtl/core/fesg_ctrl.sv =====
// Sequencer of the filled ellipse span generator: setup, per-row search, output.
// Depends on fesg_pkg for the command and status structs.
module fesg_ctrl
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    input  fesg_pkg::dp_status_t   status,
    output fesg_pkg::ctrl_cmd_t    cmd
);

    localparam logic [2:0] ST_IDLE    = 3'd0;
    localparam logic [2:0] ST_SQUARE  = 3'd1;
    localparam logic [2:0] ST_LIMIT   = 3'd2;
    localparam logic [2:0] ST_ROWSQ   = 3'd3;
    localparam logic [2:0] ST_ROWINIT = 3'd4;
    localparam logic [2:0] ST_SEARCH  = 3'd5;
    localparam logic [2:0] ST_EMIT    = 3'd6;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        m_tvalid   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_SQUARE;
                end
            end
            ST_SQUARE:
            begin
                cmd.square = 1'b1;
                state_next = ST_LIMIT;
            end
            ST_LIMIT:
            begin
                cmd.limit  = 1'b1;
                state_next = ST_ROWSQ;
            end
            ST_ROWSQ:
            begin
                cmd.row_square = 1'b1;
                state_next     = ST_ROWINIT;
            end
            ST_ROWINIT:
            begin
                cmd.row_init = 1'b1;
                state_next   = ST_SEARCH;
            end
            ST_SEARCH:
            begin
                if (status.search_done)
                begin
                    state_next = ST_EMIT;
                end
                else
                begin
                    cmd.step = 1'b1;
                end
            end
            ST_EMIT:
            begin
                m_tvalid = 1'b1;
                if (m_tready)
                begin
                    if (status.last_row)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        cmd.row_next = 1'b1;
                        state_next   = ST_ROWSQ;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/core/fesg_datapath.sv =====
// Datapath of the filled ellipse span generator: held command, squares,
// products and the incremental half-width search. Depends on fesg_pkg.
module fesg_datapath
(
    input  logic                              clk,
    input  fesg_pkg::ctrl_cmd_t               cmd,
    input  logic [fesg_pkg::IN_DATA_W-1:0]    in_data,
    output fesg_pkg::dp_status_t              status,
    output logic signed [fesg_pkg::SPAN_W-1:0] span_row,
    output logic signed [fesg_pkg::SPAN_W-1:0] span_left,
    output logic [fesg_pkg::SPAN_W-1:0]       span_right,
    output logic                              span_color
);

    logic [fesg_pkg::CX_W-1:0]         cx_reg;
    logic [fesg_pkg::CY_W-1:0]         cy_reg;
    logic [fesg_pkg::RX_W-1:0]         rx_reg;
    logic [fesg_pkg::RY_W-1:0]         ry_reg;
    logic                              color_reg;
    logic signed [fesg_pkg::ROW_W-1:0] y_reg;
    logic [fesg_pkg::RX2_W-1:0]        rx2_reg;
    logic [fesg_pkg::RY2_W-1:0]        ry2_reg;
    logic [fesg_pkg::PROD_W-1:0]       lim_reg;
    logic [fesg_pkg::STEP_W-1:0]       d0_reg;
    logic [fesg_pkg::RY2_W-1:0]        y2_reg;
    logic [fesg_pkg::PROD_W-1:0]       used_reg;
    logic [fesg_pkg::PROD_W-1:0]       t_reg;
    logic [fesg_pkg::STEP_W-1:0]       d_reg;
    logic [fesg_pkg::RX_W-1:0]         w_reg;

    logic [fesg_pkg::RY_W-1:0]         ay;
    logic [fesg_pkg::PROD_W:0]         lhs;
    logic [fesg_pkg::RX_W:0]           odd_rx;

    function automatic logic signed [fesg_pkg::SPAN_W-1:0] SPAN_W_EXT
        (input logic signed [fesg_pkg::ROW_W-1:0] v);
        SPAN_W_EXT = {{(fesg_pkg::SPAN_W - fesg_pkg::ROW_W){v[fesg_pkg::ROW_W-1]}}, v};
    endfunction

    assign ay     = y_reg[fesg_pkg::ROW_W-1] ? fesg_pkg::RY_W'(-y_reg)
                                             : fesg_pkg::RY_W'(y_reg);
    assign lhs    = {1'b0, t_reg} + {1'b0, used_reg};
    assign odd_rx = {rx_reg, 1'b0} - 7'd1;

    // t_reg holds w^2*ry^2 and d_reg holds (2w-1)*ry^2 for the current w,
    // so each narrowing step costs only subtractions.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            cx_reg    <= in_data[6:0];
            cy_reg    <= in_data[12:7];
            rx_reg    <= in_data[18:13];
            ry_reg    <= in_data[23:19];
            color_reg <= in_data[24];
            y_reg     <= -$signed({1'b0, in_data[23:19]});
        end
        if (cmd.square)
        begin
            rx2_reg <= fesg_pkg::RX2_W'(rx_reg) * fesg_pkg::RX2_W'(rx_reg);
            ry2_reg <= fesg_pkg::RY2_W'(ry_reg) * fesg_pkg::RY2_W'(ry_reg);
        end
        if (cmd.limit)
        begin
            lim_reg <= fesg_pkg::PROD_W'(rx2_reg) * fesg_pkg::PROD_W'(ry2_reg);
            d0_reg  <= fesg_pkg::STEP_W'(odd_rx) * fesg_pkg::STEP_W'(ry2_reg);
        end
        if (cmd.row_square)
        begin
            y2_reg <= fesg_pkg::RY2_W'(ay) * fesg_pkg::RY2_W'(ay);
        end
        if (cmd.row_init)
        begin
            used_reg <= fesg_pkg::PROD_W'(y2_reg) * fesg_pkg::PROD_W'(rx2_reg);
            t_reg    <= lim_reg;
            d_reg    <= d0_reg;
            w_reg    <= rx_reg;
        end
        if (cmd.step)
        begin
            t_reg <= t_reg - fesg_pkg::PROD_W'(d_reg);
            d_reg <= d_reg - fesg_pkg::STEP_W'({ry2_reg, 1'b0});
            w_reg <= w_reg - 6'd1;
        end
        if (cmd.row_next)
        begin
            y_reg <= y_reg + 6'sd1;
        end
    end

    assign status.search_done = (w_reg == '0) || (lhs <= {1'b0, lim_reg});
    assign status.last_row    = (y_reg == $signed({1'b0, ry_reg}));

    assign span_row   = $signed({2'b00, cy_reg}) + SPAN_W_EXT(y_reg);
    assign span_left  = $signed({1'b0, cx_reg} - {2'b00, w_reg});
    assign span_right = {1'b0, cx_reg} + {2'b00, w_reg};
    assign span_color = color_reg;

endmodule

// ===== rtl/core/filled_ellipse_span_generator.sv =====
// Top level of the filled ellipse span generator.
// Instantiates fesg_ctrl and fesg_datapath; depends on fesg_pkg.
//
// Usage:
//   A draw command enters on the s_ channel as one beat. The block then
//   returns 2*radius_y+1 span beats on the m_ channel, top row first; each
//   span is one row with inclusive left and right columns, and m_tlast marks
//   the bottom row. Coordinates are not clipped.
//   After the command beat the sequencer squares both radii, forms the bound
//   and first width step, squares the row offset, starts the row search and
//   narrows the half width until the span fits, then offers the span. One
//   command is in work at a time; each row repeats the row square, start,
//   search and output, and waits while the receiver stalls. The search takes
//   k = radius_x - half_width <= 63 steps per row, one pixel per cycle.
//   s_tready is high only while no command is in work.
//   A stalled span is held on m_tdata and m_tlast until m_tready.
//   Reset returns the sequencer to idle; any command in work is dropped.
module filled_ellipse_span_generator
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // center_x[6:0], center_y[12:7], radius_x[18:13], radius_y[23:19],
    // fill_color[24], zero pad[31:25]
    input  logic [fesg_pkg::IN_DATA_W-1:0]      s_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // span_row[7:0], span_left[15:8], span_right[23:16], span_color[24],
    // zero pad[31:25]
    output logic [fesg_pkg::OUT_DATA_W-1:0]     m_tdata,
    output logic                                m_tlast
);

    fesg_pkg::ctrl_cmd_t                 cmd;
    fesg_pkg::dp_status_t                status;
    logic signed [fesg_pkg::SPAN_W-1:0]  span_row;
    logic signed [fesg_pkg::SPAN_W-1:0]  span_left;
    logic [fesg_pkg::SPAN_W-1:0]         span_right;
    logic                                span_color;

    fesg_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    fesg_datapath u_datapath
    (
        .clk        (clk),
        .cmd        (cmd),
        .in_data    (s_tdata),
        .status     (status),
        .span_row   (span_row),
        .span_left  (span_left),
        .span_right (span_right),
        .span_color (span_color)
    );

    assign m_tdata = {7'd0, span_color, span_right, span_left, span_row};
    assign m_tlast = status.last_row;

endmodule

// ===== rtl/core/fesg_checker.sv =====
// Port-level checks for the filled ellipse span generator, bound to the top level.
// Depends only on the top level's ports.
module fesg_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic        m_tlast
);

    // A stalled span beat holds still.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("span beat changed while stalled");

    // No new command is taken while spans are being returned.
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_tready && m_tvalid))
        else $error("command port open while a span is pending");

    // Taking a command closes the command port.
    a_busy_after_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("command port open right after a command");

    // The last span of a command frees the command port.
    a_idle_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready && m_tlast |=> s_tready && !m_tvalid)
        else $error("block not idle after the last span");

    // Every span covers at least one pixel.
    a_span_order: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> $signed({1'b0, m_tdata[23:16]}) >= $signed(m_tdata[15:8]))
        else $error("span right edge left of its left edge");

endmodule

bind filled_ellipse_span_generator fesg_checker u_fesg_checker (.*);
